[hdl/stst_pkg.sv]
// shared types and constants of the two-ended sprite slot table
// no dependencies; used by stst_ffs and two_ended_sprite_slot_table
package stst_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = SLOT_W + 1;

	typedef enum logic [3:0] {
		OP_ADD       = 4'd0,
		OP_REMOVE    = 4'd1,
		OP_LAYER     = 4'd2,
		OP_IMAGE     = 4'd3,
		OP_TRANSFORM = 4'd4,
		OP_FRAME     = 4'd5,
		OP_VISIBLE   = 4'd6,
		OP_COLOR     = 4'd7,
		OP_TAG       = 4'd8,
		OP_QUERY     = 4'd9,
		OP_DRAW      = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_SLOT = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]  operation;
		logic [5:0]  slot;
		logic [31:0] image_handle;
		logic [31:0] transform_handle;
		logic [15:0] frame_number;
		logic [31:0] tint;
		logic        show;
		logic        on_top;
		logic [31:0] user_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  out_slot;
		logic [31:0] out_image;
		logic [31:0] out_transform;
		logic [15:0] out_frame;
		logic [31:0] out_tint;
		logic        out_visible;
		logic        out_layer;
		logic [31:0] out_user_tag;
		logic        last;
	} rsp_t;

	// per-slot word: layer, draw position, user tag
	typedef struct packed {
		logic              layer;
		logic [SLOT_W-1:0] pos;
		logic [31:0]       tag;
	} slot_word_t;

	// per-position draw entry
	typedef struct packed {
		logic [SLOT_W-1:0] owner;
		logic [31:0]       image;
		logic [31:0]       xform;
		logic [15:0]       frame;
		logic [31:0]       tint;
	} entry_word_t;

endpackage

[hdl/stst_ram.sv]
// generic single-write, single-read synchronous ram, registered read data
// no package dependency
module stst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/stst_ffs.sv]
// lowest free slot finder, one register stage of group flags
// depends on stst_pkg
module stst_ffs (
	input  logic                          clk,
	input  logic [stst_pkg::CAPACITY-1:0] free,
	output logic                          found,
	output logic [stst_pkg::SLOT_W-1:0]   slot
);
	import stst_pkg::*;

	localparam int GRP    = 8;
	localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
	localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int BSEL_W = $clog2(GRP);

	logic [NGRP*GRP-1:0] free_pad;
	logic [NGRP*GRP-1:0] free_s1;
	logic [NGRP-1:0]     grp_s1;
	logic [GSEL_W-1:0]   gsel;
	logic [BSEL_W-1:0]   bsel;
	logic [GRP-1:0]      bits;

	assign free_pad = (NGRP*GRP)'(free);

	// per-group flags: set when the group holds a free slot
	always_ff @(posedge clk) begin
		free_s1 <= free_pad;
		for (int g = 0; g < NGRP; g++) begin
			grp_s1[g] <= |free_pad[g*GRP +: GRP];
		end
	end

	// first group, then first bit inside it
	always_comb begin
		found = 1'b0;
		gsel  = '0;
		bsel  = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_s1[g]) begin
				found = 1'b1;
				gsel  = GSEL_W'(g);
			end
		end
		bits = free_s1[gsel*GRP +: GRP];
		for (int b = GRP - 1; b >= 0; b--) begin
			if (bits[b]) begin
				bsel = BSEL_W'(b);
			end
		end
		slot = SLOT_W'(gsel * GRP + bsel);
	end

endmodule

[hdl/two_ended_sprite_slot_table.sv]
// sprite slot table top level: sequencer, slot and entry memories
// depends on stst_pkg, stst_ram, stst_ffs
//
// channel   signals                 handshake
// request   start, req, busy        taken when start high and busy low
// result    strobe, rsp             one cycle per result, no back pressure
// config    cfg_we, cfg_wdata       written on any cycle with cfg_we high
//
// add runs through the find state; set and query read the slot word, then the entry;
// remove and layer change add the move and put states of the serial read-modify-write on the two memories
// a bad slot or an ignored operation code is handled in the idle state
// draw scans every position below capacity and reads the entry and slot word of each visible entry
// reset clears allocation, visibility and counts; no clearing pass is run
// results are registered and appear in the cycle after the step that makes them; the receiver cannot stall
module two_ended_sprite_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  stst_pkg::req_t              req,
	input  logic                        cfg_we,
	input  logic [stst_pkg::CNT_W-1:0]  cfg_wdata,
	output logic                        strobe,
	output stst_pkg::rsp_t              rsp
);
	import stst_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_FIND  = 11'b00000000010,
		S_RD_S  = 11'b00000000100,
		S_RD_E  = 11'b00000001000,
		S_MV_WR = 11'b00000010000,
		S_MV_S  = 11'b00000100000,
		S_PUT   = 11'b00001000000,
		S_DR_SC = 11'b00010000000,
		S_DR_E  = 11'b00100000000,
		S_DR_S  = 11'b01000000000,
		S_SPARE = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0]    cap_q, bcnt_q, tcnt_q, idx_q;
	logic [CAPACITY-1:0] alloc_q, shown_q, capmask, free, beyond;
	req_t                req_q;
	logic [SLOT_W-1:0]   pos_q, lastp_q, mv_owner_q;
	logic                layer_q, vis_q;
	logic [31:0]         tag_q;
	entry_word_t         ent_q, ent_new;
	rsp_t                rsp_q, rsp_d;
	logic                strobe_q, rsp_en;

	logic               s_we, e_we;
	logic [SLOT_W-1:0]  s_waddr, s_raddr, e_waddr, e_raddr;
	slot_word_t         s_wdata, s_rdata;
	entry_word_t        e_wdata, e_rdata;

	logic              ffs_found;
	logic [SLOT_W-1:0] ffs_slot;
	logic [SLOT_W-1:0] newp, lastp;
	logic              accept, add_ok, take_out, moving, out_range;
	logic [CNT_W:0]    used;
	logic [CNT_W-1:0]  cap_clamped;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// position masks
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			capmask[k] = (CNT_W'(k) < cap_q);
			beyond[k]  = shown_q[k] && capmask[k] && (CNT_W'(k) > idx_q);
		end
	end
	assign free = ~alloc_q & capmask;

	stst_ffs u_ffs (
		.clk   (clk),
		.free  (free),
		.found (ffs_found),
		.slot  (ffs_slot)
	);

	stst_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(CAPACITY)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	stst_ram #(.WIDTH($bits(entry_word_t)), .DEPTH(CAPACITY)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// derived positions and checks
	assign newp      = req_q.on_top ? SLOT_W'(cap_q - 1'b1 - tcnt_q) : SLOT_W'(bcnt_q);
	assign lastp     = layer_q ? SLOT_W'(cap_q - tcnt_q) : SLOT_W'(bcnt_q - 1'b1);
	assign used      = {1'b0, bcnt_q} + {1'b0, tcnt_q};
	assign add_ok    = (used < {1'b0, cap_q}) && ffs_found;
	assign out_range = ({1'b0, req.slot} >= cap_q) || !alloc_q[req.slot];
	assign take_out  = (req_q.operation == OP_REMOVE) ||
		((req_q.operation == OP_LAYER) && (layer_q != req_q.on_top));
	assign moving    = (lastp != pos_q);
	assign cap_clamped = (cfg_wdata == '0) ? CNT_W'(1) :
		((cfg_wdata > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cfg_wdata);

	// entry after a field write
	always_comb begin
		ent_new       = e_rdata;
		ent_new.owner = req_q.slot;
		if (req_q.operation == OP_IMAGE) begin
			ent_new.image = req_q.image_handle;
		end
		if (req_q.operation == OP_TRANSFORM) begin
			ent_new.xform = req_q.transform_handle;
		end
		if (req_q.operation == OP_FRAME) begin
			ent_new.frame = req_q.frame_number;
		end
		if (req_q.operation == OP_COLOR) begin
			ent_new.tint = req_q.tint;
		end
	end

	// sequencer, memory ports and result
	always_comb begin
		state_d = state_q;
		s_raddr = req_q.slot;
		s_we    = 1'b0;
		s_waddr = req_q.slot;
		s_wdata = '0;
		e_raddr = pos_q;
		e_we    = 1'b0;
		e_waddr = pos_q;
		e_wdata = '0;
		rsp_en  = 1'b0;
		rsp_d   = '0;
		rsp_d.last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				s_raddr = req.slot;
				if (accept) begin
					if (req.operation == OP_DRAW) begin
						state_d = S_DR_SC;
					end else if (req.operation == OP_ADD) begin
						state_d = S_FIND;
					end else if (req.operation < OP_DRAW) begin
						if (out_range) begin
							rsp_en         = 1'b1;
							rsp_d.status   = ST_NO_SLOT;
							rsp_d.out_slot = req.slot;
						end else begin
							state_d = S_RD_S;
						end
					end
				end
			end
			S_FIND: begin
				state_d = S_IDLE;
				rsp_en  = 1'b1;
				if (add_ok) begin
					s_we    = 1'b1;
					s_waddr = ffs_slot;
					s_wdata = '{layer: req_q.on_top, pos: newp, tag: req_q.user_tag};
					e_we    = 1'b1;
					e_waddr = newp;
					e_wdata = '{owner: ffs_slot, image: req_q.image_handle,
						xform: req_q.transform_handle, frame: req_q.frame_number,
						tint: req_q.tint};
					rsp_d.status        = ST_OK;
					rsp_d.out_slot      = ffs_slot;
					rsp_d.out_image     = req_q.image_handle;
					rsp_d.out_transform = req_q.transform_handle;
					rsp_d.out_frame     = req_q.frame_number;
					rsp_d.out_tint      = req_q.tint;
					rsp_d.out_visible   = req_q.show;
					rsp_d.out_layer     = req_q.on_top;
					rsp_d.out_user_tag  = req_q.user_tag;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			S_RD_S: begin
				e_raddr = s_rdata.pos;
				state_d = S_RD_E;
			end
			S_RD_E: begin
				e_raddr = lastp;
				if (take_out) begin
					if (moving) begin
						state_d = S_MV_WR;
					end else if (req_q.operation == OP_REMOVE) begin
						state_d        = S_IDLE;
						rsp_en         = 1'b1;
						rsp_d.status   = ST_OK;
						rsp_d.out_slot = req_q.slot;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					state_d = S_IDLE;
					if ((req_q.operation == OP_IMAGE) || (req_q.operation == OP_TRANSFORM) ||
						(req_q.operation == OP_FRAME) || (req_q.operation == OP_COLOR)) begin
						e_we    = 1'b1;
						e_wdata = ent_new;
					end
					if (req_q.operation == OP_TAG) begin
						s_we    = 1'b1;
						s_wdata = '{layer: layer_q, pos: pos_q, tag: req_q.user_tag};
					end
					rsp_en              = 1'b1;
					rsp_d.status        = ST_OK;
					rsp_d.out_slot      = req_q.slot;
					rsp_d.out_image     = ent_new.image;
					rsp_d.out_transform = ent_new.xform;
					rsp_d.out_frame     = ent_new.frame;
					rsp_d.out_tint      = ent_new.tint;
					rsp_d.out_visible   = (req_q.operation == OP_VISIBLE) ?
						req_q.show : shown_q[pos_q];
					rsp_d.out_layer     = layer_q;
					rsp_d.out_user_tag  = (req_q.operation == OP_TAG) ? req_q.user_tag : tag_q;
				end
			end
			S_MV_WR: begin
				e_we    = 1'b1;
				e_wdata = e_rdata;
				s_raddr = e_rdata.owner;
				state_d = S_MV_S;
			end
			S_MV_S: begin
				s_we    = 1'b1;
				s_waddr = mv_owner_q;
				s_wdata = '{layer: s_rdata.layer, pos: pos_q, tag: s_rdata.tag};
				if (req_q.operation == OP_REMOVE) begin
					state_d        = S_IDLE;
					rsp_en         = 1'b1;
					rsp_d.status   = ST_OK;
					rsp_d.out_slot = req_q.slot;
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				s_we    = 1'b1;
				s_wdata = '{layer: req_q.on_top, pos: newp, tag: tag_q};
				e_we    = 1'b1;
				e_waddr = newp;
				e_wdata = '{owner: req_q.slot, image: ent_q.image, xform: ent_q.xform,
					frame: ent_q.frame, tint: ent_q.tint};
				state_d             = S_IDLE;
				rsp_en              = 1'b1;
				rsp_d.status        = ST_OK;
				rsp_d.out_slot      = req_q.slot;
				rsp_d.out_image     = ent_q.image;
				rsp_d.out_transform = ent_q.xform;
				rsp_d.out_frame     = ent_q.frame;
				rsp_d.out_tint      = ent_q.tint;
				rsp_d.out_visible   = vis_q;
				rsp_d.out_layer     = req_q.on_top;
				rsp_d.out_user_tag  = tag_q;
			end
			S_DR_SC: begin
				e_raddr = SLOT_W'(idx_q);
				if (idx_q >= cap_q) begin
					state_d = S_IDLE;
				end else if (shown_q[SLOT_W'(idx_q)]) begin
					state_d = S_DR_E;
				end
			end
			S_DR_E: begin
				s_raddr = e_rdata.owner;
				state_d = S_DR_S;
			end
			S_DR_S: begin
				state_d             = S_DR_SC;
				rsp_en              = 1'b1;
				rsp_d.status        = ST_OK;
				rsp_d.out_slot      = ent_q.owner;
				rsp_d.out_image     = ent_q.image;
				rsp_d.out_transform = ent_q.xform;
				rsp_d.out_frame     = ent_q.frame;
				rsp_d.out_tint      = ent_q.tint;
				rsp_d.out_visible   = 1'b1;
				rsp_d.out_layer     = s_rdata.layer;
				rsp_d.out_user_tag  = s_rdata.tag;
				rsp_d.last          = ~|beyond;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= CNT_W'(CAPACITY);
			bcnt_q   <= '0;
			tcnt_q   <= '0;
			alloc_q  <= '0;
			shown_q  <= '0;
			strobe_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= rsp_en;
			if (cfg_we) begin
				cap_q   <= cap_clamped;
				bcnt_q  <= '0;
				tcnt_q  <= '0;
				alloc_q <= '0;
				shown_q <= '0;
			end
			if (accept) begin
				idx_q <= '0;
			end
			if ((state_q == S_FIND) && add_ok) begin
				alloc_q[ffs_slot] <= 1'b1;
				shown_q[newp]     <= req_q.show;
				if (req_q.on_top) begin
					tcnt_q <= tcnt_q + 1'b1;
				end else begin
					bcnt_q <= bcnt_q + 1'b1;
				end
			end
			if (state_q == S_RD_E) begin
				if (req_q.operation == OP_VISIBLE) begin
					shown_q[pos_q] <= req_q.show;
				end
				if (req_q.operation == OP_REMOVE) begin
					alloc_q[req_q.slot] <= 1'b0;
				end
				if (take_out) begin
					shown_q[pos_q] <= 1'b0;
					if (layer_q) begin
						tcnt_q <= tcnt_q - 1'b1;
					end else begin
						bcnt_q <= bcnt_q - 1'b1;
					end
				end
			end
			if (state_q == S_MV_WR) begin
				shown_q[pos_q]   <= shown_q[lastp_q];
				shown_q[lastp_q] <= 1'b0;
			end
			if (state_q == S_PUT) begin
				shown_q[newp] <= vis_q;
				if (req_q.on_top) begin
					tcnt_q <= tcnt_q + 1'b1;
				end else begin
					bcnt_q <= bcnt_q + 1'b1;
				end
			end
			if ((state_q == S_DR_SC) && (idx_q < cap_q) && !shown_q[SLOT_W'(idx_q)]) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == S_DR_S) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// request and working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_en) begin
			rsp_q <= rsp_d;
		end
		if (state_q == S_RD_S) begin
			layer_q <= s_rdata.layer;
			pos_q   <= s_rdata.pos;
			tag_q   <= s_rdata.tag;
		end
		if (state_q == S_RD_E) begin
			ent_q   <= e_rdata;
			vis_q   <= shown_q[pos_q];
			lastp_q <= lastp;
		end
		if (state_q == S_MV_WR) begin
			mv_owner_q <= e_rdata.owner;
		end
		if (state_q == S_DR_E) begin
			ent_q <= e_rdata;
		end
	end

`ifndef SYNTHESIS
	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, bcnt_q} + {1'b0, tcnt_q}) <= {1'b0, cap_q})
		else $error("layer counts exceed capacity");

	a_alloc_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		($countones(alloc_q) == (32'(bcnt_q) + 32'(tcnt_q))))
		else $error("allocated slots disagree with entry counts");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (!s_we && !e_we))
		else $error("memory written while idle");

	a_strobe_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy || start))
		else $error("result without a request");
`endif

endmodule

[bench/two_ended_sprite_slot_table_tb.sv]
// self-checking testbench for the two-ended sprite slot table
// depends on stst_pkg and two_ended_sprite_slot_table; keeps its own table model
// and compares every result strobe against the model's prediction
module two_ended_sprite_slot_table_tb;
	import stst_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 300;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                strobe;
	rsp_t                rsp;

	// table model
	logic        sl_alloc [CAPACITY];
	logic        sl_layer [CAPACITY];
	logic [5:0]  sl_pos   [CAPACITY];
	logic [31:0] sl_tag   [CAPACITY];
	logic [5:0]  en_owner [CAPACITY];
	logic [31:0] en_image [CAPACITY];
	logic [31:0] en_xform [CAPACITY];
	logic [15:0] en_frame [CAPACITY];
	logic [31:0] en_tint  [CAPACITY];
	logic        en_shown [CAPACITY];
	int unsigned bottom_cnt, top_cnt, cap_used;

	rsp_t        pending_rsp[$];
	int          errors;
	int          cycles;

	two_ended_sprite_slot_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void empty_table();
		for (int i = 0; i < CAPACITY; i++) begin
			sl_alloc[i] = 1'b0;
			en_shown[i] = 1'b0;
		end
		bottom_cnt = 0;
		top_cnt = 0;
	endfunction

	function automatic rsp_t slot_view(int s);
		rsp_t r;
		int p;
		p = int'(sl_pos[s]);
		r.status = ST_OK;
		r.out_slot = s[5:0];
		r.out_image = en_image[p];
		r.out_transform = en_xform[p];
		r.out_frame = en_frame[p];
		r.out_tint = en_tint[p];
		r.out_visible = en_shown[p];
		r.out_layer = sl_layer[s];
		r.out_user_tag = sl_tag[s];
		r.last = 1'b1;
		return r;
	endfunction

	function automatic rsp_t blank_view(status_t st, int s);
		rsp_t r;
		r = '0;
		r.status = st;
		r.out_slot = s[5:0];
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void move_entry(int from, int to);
		en_owner[to] = en_owner[from];
		en_image[to] = en_image[from];
		en_xform[to] = en_xform[from];
		en_frame[to] = en_frame[from];
		en_tint[to]  = en_tint[from];
		en_shown[to] = en_shown[from];
		en_shown[from] = 1'b0;
		sl_pos[en_owner[to]] = to[5:0];
	endfunction

	// pull the slot's entry out of its layer, last entry of the layer fills the hole
	function automatic void take_out(int s);
		int p, lastp;
		p = int'(sl_pos[s]);
		en_shown[p] = 1'b0;
		if (!sl_layer[s]) begin
			lastp = (bottom_cnt - 1) & 63;
			if (p != lastp) move_entry(lastp, p);
			bottom_cnt--;
		end else begin
			lastp = (cap_used - top_cnt) & 63;
			if (p != lastp) move_entry(lastp, p);
			top_cnt--;
		end
	endfunction

	function automatic int put_in(int s, logic top);
		int p;
		if (!top) begin
			p = bottom_cnt & 63;
			bottom_cnt++;
		end else begin
			p = (cap_used - 1 - top_cnt) & 63;
			top_cnt++;
		end
		sl_layer[s] = top;
		sl_pos[s] = p[5:0];
		en_owner[p] = s[5:0];
		return p;
	endfunction

	// expected results of one accepted request
	function automatic void predict_table(req_t r);
		int s, p, n;
		rsp_t v;
		logic [31:0] si, sx, st;
		logic [15:0] sf;
		logic sv;
		s = int'(r.slot);
		if (r.operation > OP_DRAW) return;
		if (r.operation == OP_DRAW) begin
			n = 0;
			for (int i = 0; i < cap_used; i++) begin
				if (en_shown[i]) begin
					v = slot_view(int'(en_owner[i]));
					v.last = 1'b0;
					pending_rsp.push_back(v);
					n++;
				end
			end
			if (n > 0) pending_rsp[pending_rsp.size() - 1].last = 1'b1;
			return;
		end
		if (r.operation == OP_ADD) begin
			s = -1;
			if (bottom_cnt + top_cnt < cap_used) begin
				for (int i = cap_used - 1; i >= 0; i--)
					if (!sl_alloc[i]) s = i;
			end
			if (s < 0) begin
				pending_rsp.push_back(blank_view(ST_FULL, 0));
				return;
			end
			sl_alloc[s] = 1'b1;
			p = put_in(s, r.on_top);
			en_image[p] = r.image_handle;
			en_xform[p] = r.transform_handle;
			en_frame[p] = r.frame_number;
			en_tint[p]  = r.tint;
			en_shown[p] = r.show;
			sl_tag[s] = r.user_tag;
			pending_rsp.push_back(slot_view(s));
			return;
		end
		if (s >= cap_used || !sl_alloc[s]) begin
			pending_rsp.push_back(blank_view(ST_NO_SLOT, s));
			return;
		end
		p = int'(sl_pos[s]);
		case (op_t'(r.operation))
			OP_REMOVE: begin
				take_out(s);
				sl_alloc[s] = 1'b0;
				pending_rsp.push_back(blank_view(ST_OK, s));
				return;
			end
			OP_LAYER: begin
				if (sl_layer[s] != r.on_top) begin
					si = en_image[p]; sx = en_xform[p]; sf = en_frame[p];
					st = en_tint[p]; sv = en_shown[p];
					take_out(s);
					p = put_in(s, r.on_top);
					en_image[p] = si; en_xform[p] = sx; en_frame[p] = sf;
					en_tint[p] = st; en_shown[p] = sv;
				end
			end
			OP_IMAGE:     en_image[p] = r.image_handle;
			OP_TRANSFORM: en_xform[p] = r.transform_handle;
			OP_FRAME:     en_frame[p] = r.frame_number;
			OP_VISIBLE:   en_shown[p] = r.show;
			OP_COLOR:     en_tint[p]  = r.tint;
			OP_TAG:       sl_tag[s]   = r.user_tag;
			default: ;
		endcase
		pending_rsp.push_back(slot_view(s));
	endfunction

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && strobe) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected result expected none actual %h", $time, rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				check_field("status", 32'(e.status), 32'(rsp.status));
				check_field("out_slot", 32'(e.out_slot), 32'(rsp.out_slot));
				check_field("out_image", e.out_image, rsp.out_image);
				check_field("out_transform", e.out_transform, rsp.out_transform);
				check_field("out_frame", 32'(e.out_frame), 32'(rsp.out_frame));
				check_field("out_tint", e.out_tint, rsp.out_tint);
				check_field("out_visible", 32'(e.out_visible), 32'(rsp.out_visible));
				check_field("out_layer", 32'(e.out_layer), 32'(rsp.out_layer));
				check_field("out_user_tag", e.out_user_tag, rsp.out_user_tag);
				check_field("last", 32'(e.last), 32'(rsp.last));
			end
		end
	end

	// send one request; start is left high for a following request
	task automatic send_req(req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_table(r);
	endtask

	task automatic pause_sender(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic req_t rand_req(op_t op, int s);
		req_t r;
		r.operation = op;
		r.slot = s[5:0];
		r.image_handle = $urandom;
		r.transform_handle = $urandom;
		r.frame_number = 16'($urandom);
		r.tint = $urandom;
		r.show = 1'($urandom_range(0, 1));
		r.on_top = 1'($urandom_range(0, 1));
		r.user_tag = $urandom;
		return r;
	endfunction

	function automatic req_t edge_req(op_t op, int s, logic ones);
		req_t r;
		r = ones ? '1 : '0;
		r.operation = op;
		r.slot = s[5:0];
		return r;
	endfunction

	// capacity write, only with the table idle
	task automatic write_capacity(int v);
		pause_sender(1);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_used = (v & 127) < 1 ? 1 : ((v & 127) > CAPACITY ? CAPACITY : (v & 127));
		empty_table();
	endtask

	task automatic test_directed();
		write_capacity(64);
		send_req(edge_req(OP_ADD, 0, 1'b1));          // top layer, all ones
		send_req(edge_req(OP_ADD, 0, 1'b0));          // bottom layer, all zeros
		send_req(rand_req(OP_ADD, 0));
		send_req(edge_req(OP_VISIBLE, 1, 1'b1));
		send_req(edge_req(OP_IMAGE, 1, 1'b1));
		send_req(edge_req(OP_TRANSFORM, 1, 1'b1));
		send_req(edge_req(OP_FRAME, 1, 1'b1));
		send_req(edge_req(OP_COLOR, 1, 1'b1));
		send_req(edge_req(OP_TAG, 1, 1'b1));
		send_req(edge_req(OP_QUERY, 0, 1'b0));
		send_req(edge_req(OP_DRAW, 0, 1'b0));
		send_req(edge_req(OP_LAYER, 1, 1'b0));        // slot stays in the bottom layer: nothing moves
		send_req(edge_req(OP_LAYER, 0, 1'b1));        // same layer: nothing moves
		send_req(edge_req(OP_REMOVE, 0, 1'b0));
		send_req(edge_req(OP_QUERY, 0, 1'b0));        // not allocated
		send_req(edge_req(OP_QUERY, 63, 1'b1));       // never allocated slot
		send_req(edge_req(op_t'(4'd11), 0, 1'b0));    // ignored codes
		send_req(edge_req(op_t'(4'd15), 63, 1'b1));
		send_req(edge_req(OP_DRAW, 0, 1'b0));
		// tiny table: fill, full, slot beyond capacity
		write_capacity(0);
		send_req(edge_req(OP_ADD, 0, 1'b1));
		send_req(edge_req(OP_ADD, 0, 1'b1));          // full
		send_req(edge_req(OP_QUERY, 1, 1'b0));        // at capacity
		send_req(edge_req(OP_DRAW, 0, 1'b0));
		send_req(edge_req(OP_REMOVE, 0, 1'b0));
	endtask

	// mostly well-formed traffic on allocated slots, some noise
	task automatic test_random(int cap_value, int count);
		int sent, burst, pick, s, k;
		int live[$];
		req_t r;
		write_capacity(cap_value);
		sent = 0;
		burst = 0;
		while (sent < count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 10);
				if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
			end
			live.delete();
			for (int i = 0; i < cap_used; i++) if (sl_alloc[i]) live.push_back(i);
			s = $urandom_range(0, 63);
			if (live.size() > 0 && $urandom_range(0, 9) < 8)
				s = live[$urandom_range(0, live.size() - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 25) r = rand_req(OP_ADD, s);
			else if (pick < 35) r = rand_req(OP_REMOVE, s);
			else if (pick < 45) r = rand_req(OP_LAYER, s);
			else if (pick < 70) r = rand_req(op_t'($urandom_range(3, 8)), s);
			else if (pick < 80) r = rand_req(OP_QUERY, s);
			else if (pick < 92) r = rand_req(OP_DRAW, s);
			else begin
				k = $urandom_range(11, 15);
				r = rand_req(op_t'(k), s);
			end
			send_req(r);
			if (r.operation <= OP_DRAW) sent++;
			burst--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		cap_used = CAPACITY;
		empty_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(64, 60);
		test_random(5, 30);
		test_random(127, 25);
		test_random(2, 20);
		pause_sender(1);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
